[sv/sdp_pkg.sv]
// Shared types and constants for the stereo disparity to point unit.
`default_nettype none
package sdp_pkg;

    // Field widths of the stream words and the configuration port.
    localparam int PIX_W   = 16;
    localparam int CFG_W   = 16;
    localparam int CFG_AW  = 3;
    localparam int COORD_W = 32;
    localparam int IN_TDATA_W  = 3 * PIX_W;
    localparam int OUT_TDATA_W = 3 * COORD_W;

    // Offsets are 17-bit signed, the disparity 18-bit signed.
    localparam int OFF_W  = PIX_W + 1;
    localparam int DISP_W = PIX_W + 2;
    // Products of a 16-bit register and a 17-bit operand.
    localparam int PROD_W = CFG_W + OFF_W;
    // Largest product magnitude is below 2^31, largest disparity magnitude below 2^17.
    localparam int AW = 31;
    localparam int DW = 17;

    // The denominator carries a fixed factor of 2^8; rounding adds 2^8, half of the 2^9 shift.
    localparam int DEN_SHIFT = 8;
    localparam int RND_SHIFT = DEN_SHIFT + 1;

    // Saturation limits as magnitudes.
    localparam logic [COORD_W:0] SAT_POS_MAG = 33'h0_7FFF_FFFF;
    localparam logic [COORD_W:0] SAT_NEG_MAG = 33'h0_8000_0000;

    // Lanes of the shared divider.
    localparam int LANES  = 3;
    localparam int LANE_X = 0;
    localparam int LANE_Y = 1;
    localparam int LANE_Z = 2;

    // Register indexes of the configuration port.
    typedef enum logic [CFG_AW-1:0] {
        REG_FOCAL = 3'd0,
        REG_BASE  = 3'd1,
        REG_LCX   = 3'd2,
        REG_LCY   = 3'd3,
        REG_RCX   = 3'd4
    } cfg_idx_t;

    localparam logic [CFG_W-1:0] FOCAL_RST = 16'd7824;
    localparam logic [CFG_W-1:0] BASE_RST  = 16'hDFD5;

    typedef struct packed {
        logic [CFG_W-1:0] focal_length;
        logic [CFG_W-1:0] baseline;
        logic [CFG_W-1:0] left_center_x;
        logic [CFG_W-1:0] left_center_y;
        logic [CFG_W-1:0] right_center_x;
    } sdp_cfg_t;

    // Control that travels beside the quotients.
    typedef struct packed {
        logic [LANES-1:0] neg;
        logic             zero;
        logic             last;
    } sdp_side_t;

endpackage
`default_nettype wire

[sv/stereo_disparity_to_point_unit.sv]
// Top level of the stereo disparity to point unit: registers and pipeline assembly.
`default_nettype none
// Triangulates one matched pair of a rectified stereo rig per word. A slave
// word carries left x, left y and right x in 1/16 pixel; the unit forms the left
// offsets from the principal point, the disparity, and returns X, Y and Z as
// signed 32-bit fixed point with OUT_FRAC_BITS fractional bits of the baseline
// unit, rounded half away from zero and saturated. A zero disparity gives
// zero coordinates with the tuser flag set; tlast passes through. The unit
// takes one word per clock cycle while the skid entry is empty. Its pipeline
// holds three front stages (offsets, multipliers, magnitudes), one stage per
// quotient bit of the shared three-lane restoring divider (OUT_FRAC_BITS + 32
// stages), two rounding and saturation stages and the output register. A
// one-word skid entry behind the output register lets the pipeline keep
// accepting while a result waits; tready falls only when that entry is full.
// Registers are written through cfg_wr_en/cfg_addr/cfg_wdata and must only be
// changed while no word is in flight; unknown addresses are ignored.
module stereo_disparity_to_point_unit #(
    parameter int OUT_FRAC_BITS = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [sdp_pkg::CFG_AW-1:0]        cfg_addr,
    input  logic [sdp_pkg::CFG_W-1:0]         cfg_wdata,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // Fields from bit 0 up: left_x, left_y, right_x.
    input  logic [sdp_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    input  logic                              s_axis_tlast,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // Fields from bit 0 up: point_x, point_y, point_z.
    output logic [sdp_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    // Fields from bit 0 up: zero_disparity.
    output logic                              m_axis_tuser,
    output logic                              m_axis_tlast
);
    import sdp_pkg::*;

    // Dividend bits: product magnitude, fractional scaling and one rounding bit.
    localparam int NUM_W = AW + OUT_FRAC_BITS + 1;

    sdp_cfg_t                    cfg_reg;
    logic                        advance;

    logic                        front_valid;
    logic [LANES-1:0][AW-1:0]    front_num;
    logic [DW-1:0]               front_den;
    sdp_side_t                   front_side;

    logic                        div_valid;
    logic [LANES-1:0][NUM_W-1:0] div_quo;
    sdp_side_t                   div_side;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.focal_length   <= FOCAL_RST;
            cfg_reg.baseline       <= BASE_RST;
            cfg_reg.left_center_x  <= '0;
            cfg_reg.left_center_y  <= '0;
            cfg_reg.right_center_x <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                REG_FOCAL: cfg_reg.focal_length   <= cfg_wdata;
                REG_BASE:  cfg_reg.baseline       <= cfg_wdata;
                REG_LCX:   cfg_reg.left_center_x  <= cfg_wdata;
                REG_LCY:   cfg_reg.left_center_y  <= cfg_wdata;
                REG_RCX:   cfg_reg.right_center_x <= cfg_wdata;
                default:   ;
            endcase
        end
    end

    // Every stage moves together; the stall comes only from a full skid entry.
    assign s_axis_tready = advance;

    sdp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (s_axis_tvalid),
        .left_x    (s_axis_tdata[PIX_W-1:0]),
        .left_y    (s_axis_tdata[2*PIX_W-1:PIX_W]),
        .right_x   (s_axis_tdata[3*PIX_W-1:2*PIX_W]),
        .last_pair (s_axis_tlast),
        .cfg       (cfg_reg),
        .out_valid (front_valid),
        .out_num   (front_num),
        .out_den   (front_den),
        .out_side  (front_side)
    );

    sdp_div #(
        .NUM_W (NUM_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (front_valid),
        .in_num    (front_num),
        .in_den    (front_den),
        .in_side   (front_side),
        .out_valid (div_valid),
        .out_quo   (div_quo),
        .out_side  (div_side)
    );

    sdp_out #(
        .NUM_W (NUM_W)
    ) u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (advance),
        .in_valid      (div_valid),
        .in_quo        (div_quo),
        .in_side       (div_side),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule
`default_nettype wire

[sv/sdp_front.sv]
// Front end: offsets and disparity, products, then magnitudes and signs.
`default_nettype none
module sdp_front (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       advance,
    input  logic                                       in_valid,
    input  logic [sdp_pkg::PIX_W-1:0]                  left_x,
    input  logic [sdp_pkg::PIX_W-1:0]                  left_y,
    input  logic [sdp_pkg::PIX_W-1:0]                  right_x,
    input  logic                                       last_pair,
    input  sdp_pkg::sdp_cfg_t                          cfg,
    output logic                                       out_valid,
    output logic [sdp_pkg::LANES-1:0][sdp_pkg::AW-1:0] out_num,
    output logic [sdp_pkg::DW-1:0]                     out_den,
    output sdp_pkg::sdp_side_t                         out_side
);
    import sdp_pkg::*;

    // Stage A: offsets and disparity.
    logic signed [OFF_W-1:0]  ox_next, oy_next, rxo_next;
    logic signed [DISP_W-1:0] disp_next;
    logic                     a_valid_reg;
    logic signed [OFF_W-1:0]  ox_reg, oy_reg;
    logic signed [DISP_W-1:0] a_disp_reg;
    logic                     a_last_reg;

    // Stage B: products.
    logic signed [CFG_W-1:0]  base_s;
    logic signed [OFF_W-1:0]  focal_s;
    logic signed [PROD_W-1:0] px_next, py_next, pz_next;
    logic                     b_valid_reg;
    logic [LANES-1:0][PROD_W-1:0] prod_reg;
    logic signed [DISP_W-1:0] b_disp_reg;
    logic                     b_last_reg;

    // Stage C: magnitudes and signs.
    logic [LANES-1:0][AW-1:0] num_next;
    logic [DW-1:0]            den_next;
    sdp_side_t                side_next;
    logic                     c_valid_reg;
    logic [LANES-1:0][AW-1:0] num_reg;
    logic [DW-1:0]            den_reg;
    sdp_side_t                side_reg;

    always_comb
    begin
        ox_next   = $signed({1'b0, left_x}) - $signed({1'b0, cfg.left_center_x});
        oy_next   = $signed({1'b0, left_y}) - $signed({1'b0, cfg.left_center_y});
        rxo_next  = $signed({1'b0, right_x}) - $signed({1'b0, cfg.right_center_x});
        disp_next = $signed({ox_next[OFF_W-1], ox_next})
                  - $signed({rxo_next[OFF_W-1], rxo_next});
    end

    assign base_s  = $signed(cfg.baseline);
    assign focal_s = $signed({1'b0, cfg.focal_length});
    assign px_next = base_s * ox_reg;
    assign py_next = base_s * oy_reg;
    assign pz_next = base_s * focal_s;

    always_comb
    begin
        logic [PROD_W-1:0] mag;
        logic [DISP_W-1:0] dmag;
        dmag = b_disp_reg[DISP_W-1] ? (DISP_W'(0) - DISP_W'(b_disp_reg))
                                    : DISP_W'(b_disp_reg);
        den_next = dmag[DW-1:0];
        for (int l = 0; l < LANES; l++)
        begin
            mag = prod_reg[l][PROD_W-1] ? (PROD_W'(0) - prod_reg[l]) : prod_reg[l];
            num_next[l] = mag[AW-1:0];
            side_next.neg[l] = prod_reg[l][PROD_W-1] ^ b_disp_reg[DISP_W-1];
        end
        side_next.zero = (b_disp_reg == '0);
        side_next.last = b_last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            ox_reg           <= ox_next;
            oy_reg           <= oy_next;
            a_disp_reg       <= disp_next;
            a_last_reg       <= last_pair;
            prod_reg[LANE_X] <= px_next;
            prod_reg[LANE_Y] <= py_next;
            prod_reg[LANE_Z] <= pz_next;
            b_disp_reg       <= a_disp_reg;
            b_last_reg       <= a_last_reg;
            num_reg          <= num_next;
            den_reg          <= den_next;
            side_reg         <= side_next;
        end
    end

    assign out_valid = c_valid_reg;
    assign out_num   = num_reg;
    assign out_den   = den_reg;
    assign out_side  = side_reg;

endmodule
`default_nettype wire

[sv/sdp_div.sv]
// Pipelined restoring divider, one quotient bit per stage, three lanes on one divisor.
`default_nettype none
module sdp_div #(
    parameter int NUM_W = 40
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       advance,
    input  logic                                       in_valid,
    input  logic [sdp_pkg::LANES-1:0][sdp_pkg::AW-1:0] in_num,
    input  logic [sdp_pkg::DW-1:0]                     in_den,
    input  sdp_pkg::sdp_side_t                         in_side,
    output logic                                       out_valid,
    output logic [sdp_pkg::LANES-1:0][NUM_W-1:0]       out_quo,
    output sdp_pkg::sdp_side_t                         out_side
);
    import sdp_pkg::*;

    // The dividend is the magnitude scaled up by the zero bits below it.
    localparam int PAD = NUM_W - AW;

    logic [NUM_W-1:0]                valid_reg;
    logic [LANES-1:0][DW-1:0]        rem_reg  [NUM_W];
    logic [LANES-1:0][DW-1:0]        rem_next [NUM_W];
    logic [LANES-1:0][NUM_W-1:0]     acc_reg  [NUM_W];
    logic [LANES-1:0][NUM_W-1:0]     acc_next [NUM_W];
    logic [DW-1:0]                   den_reg  [NUM_W];
    sdp_side_t                       side_reg [NUM_W];

    // One restoring step: the accumulator shifts its top dividend bit into the
    // remainder and takes the new quotient bit at the bottom.
    function automatic logic [DW+NUM_W-1:0] div_step(
        input logic [DW-1:0]    rem,
        input logic [NUM_W-1:0] acc,
        input logic [DW-1:0]    den
    );
        logic [DW:0]   trial;
        logic          fits;
        logic [DW-1:0] rem_n;
        trial = {rem, acc[NUM_W-1]};
        fits  = (trial >= {1'b0, den});
        rem_n = fits ? DW'(trial - {1'b0, den}) : trial[DW-1:0];
        return {rem_n, acc[NUM_W-2:0], fits};
    endfunction

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            {rem_next[0][l], acc_next[0][l]} =
                div_step('0, NUM_W'(in_num[l]) << PAD, in_den);
        end
        for (int s = 1; s < NUM_W; s++)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                {rem_next[s][l], acc_next[s][l]} =
                    div_step(rem_reg[s-1][l], acc_reg[s-1][l], den_reg[s-1]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (advance)
        begin
            valid_reg <= {valid_reg[NUM_W-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rem_reg     <= rem_next;
            acc_reg     <= acc_next;
            den_reg[0]  <= in_den;
            side_reg[0] <= in_side;
            for (int s = 1; s < NUM_W; s++)
            begin
                den_reg[s]  <= den_reg[s-1];
                side_reg[s] <= side_reg[s-1];
            end
        end
    end

    assign out_valid = valid_reg[NUM_W-1];
    assign out_quo   = acc_reg[NUM_W-1];
    assign out_side  = side_reg[NUM_W-1];

endmodule
`default_nettype wire

[sv/sdp_out.sv]
// Rounding, saturation, sign, and the output register with its skid entry.
`default_nettype none
module sdp_out #(
    parameter int NUM_W = 40
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    output logic                                      advance,
    input  logic                                      in_valid,
    input  logic [sdp_pkg::LANES-1:0][NUM_W-1:0]      in_quo,
    input  sdp_pkg::sdp_side_t                        in_side,
    output logic                                      m_axis_tvalid,
    input  logic                                      m_axis_tready,
    output logic [sdp_pkg::OUT_TDATA_W-1:0]           m_axis_tdata,
    output logic                                      m_axis_tuser,
    output logic                                      m_axis_tlast
);
    import sdp_pkg::*;

    localparam int QRW = NUM_W + 1 - RND_SHIFT;
    localparam int EW  = (QRW > COORD_W + 1) ? QRW : COORD_W + 1;

    typedef struct packed {
        logic                          last;
        logic                          zero;
        logic [LANES-1:0][COORD_W-1:0] pt;
    } out_word_t;

    logic [LANES-1:0][QRW-1:0]  rq_next;
    logic                       r1_valid_reg;
    logic [LANES-1:0][QRW-1:0]  rq_reg;
    sdp_side_t                  r1_side_reg;

    out_word_t                  r2_next;
    logic                       r2_valid_reg;
    out_word_t                  r2_word_reg;

    logic                       out_valid_reg;
    out_word_t                  out_word_reg;
    logic                       skid_valid_reg;
    out_word_t                  skid_data_reg;
    logic                       take;
    logic                       incoming;

    // Round half away from zero: quotient carries one extra bit and the 2^8 factor.
    always_comb
    begin
        logic [NUM_W:0] sum;
        for (int l = 0; l < LANES; l++)
        begin
            sum = {1'b0, in_quo[l]} + (NUM_W+1)'(1 << DEN_SHIFT);
            rq_next[l] = sum[NUM_W:RND_SHIFT];
        end
    end

    always_comb
    begin
        logic [EW-1:0]      ext;
        logic [EW-1:0]      lim;
        logic [COORD_W-1:0] mag;
        for (int l = 0; l < LANES; l++)
        begin
            ext = EW'(rq_reg[l]);
            lim = r1_side_reg.neg[l] ? EW'(SAT_NEG_MAG) : EW'(SAT_POS_MAG);
            mag = (ext > lim) ? lim[COORD_W-1:0] : ext[COORD_W-1:0];
            if (r1_side_reg.zero)
            begin
                r2_next.pt[l] = '0;
            end
            else if (r1_side_reg.neg[l])
            begin
                r2_next.pt[l] = COORD_W'(0) - mag;
            end
            else
            begin
                r2_next.pt[l] = mag;
            end
        end
        r2_next.zero = r1_side_reg.zero;
        r2_next.last = r1_side_reg.last;
    end

    // The whole pipeline moves unless the skid entry is holding a word.
    assign advance  = !skid_valid_reg;
    assign take     = out_valid_reg && m_axis_tready;
    assign incoming = r2_valid_reg && advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r1_valid_reg   <= 1'b0;
            r2_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                r1_valid_reg <= in_valid;
                r2_valid_reg <= r1_valid_reg;
            end
            if (skid_valid_reg)
            begin
                if (take)
                begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end
            end
            else if (!out_valid_reg || take)
            begin
                out_valid_reg <= incoming;
            end
            else if (incoming)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rq_reg      <= rq_next;
            r1_side_reg <= in_side;
            r2_word_reg <= r2_next;
        end
        if (skid_valid_reg)
        begin
            if (take)
            begin
                out_word_reg <= skid_data_reg;
            end
        end
        else if (!out_valid_reg || take)
        begin
            out_word_reg <= r2_word_reg;
        end
        else
        begin
            skid_data_reg <= r2_word_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_word_reg.pt;
    assign m_axis_tuser  = out_word_reg.zero;
    assign m_axis_tlast  = out_word_reg.last;

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry holds a word while the output register is empty");

    a_skid_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && !take) |=> (skid_valid_reg && $stable(skid_data_reg)))
        else $error("skid word lost or changed while the output is stalled");

    a_zero_point: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_word_reg.zero) |-> (out_word_reg.pt == '0))
        else $error("zero disparity word carries nonzero coordinates");

endmodule
`default_nettype wire
